@@ rtl/bptc_pkg.sv @@
// Constants for the barometric pressure/temperature compensation pipeline.
// Holds datapath widths, register indexes and fixed compensation terms.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

   localparam int RAW_W     = 24;   // raw conversion results
   localparam int COEF_W    = 16;   // calibration words
   localparam int CSR_IDX_W = 3;
   localparam int DT_W      = 25;   // D2 - C5*256
   localparam int TEMP_W    = 19;   // temperature, 0.01 C
   localparam int PRES_W    = 32;   // pressure, Pa
   localparam int MUL_W     = 42;   // dT times a calibration word
   localparam int DSQ_W     = 50;   // dT squared
   localparam int OFF_W     = 42;
   localparam int SENS_W    = 40;
   localparam int SQ_W      = 36;   // squared temperature deltas
   localparam int CORR_W    = 40;   // second-order correction terms
   localparam int SPLIT_W   = 20;   // low half of SENS for the split product
   localparam int PPLO_W    = 44;
   localparam int PPHI_W    = 45;
   localparam int PROD_W    = 64;
   localparam int Q_W       = 45;
   localparam int NSTG      = 9;

   localparam logic [CSR_IDX_W-1:0] REG_C1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_C2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_C3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_C4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_C5 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_C6 = 3'd5;

   // 20.00 C reference; very-low threshold -15.00 C lies 3500 below it
   localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] VLOW_OFS  = 19'sd3500;

   localparam logic signed [63:0] PRES_MAX = 64'sd2147483647;
   localparam logic signed [63:0] PRES_MIN = -64'sd2147483648;

endpackage

`default_nettype wire

@@ rtl/baro_pressure_temp_compensation_unit.sv @@
// Barometric sensor second-order compensation, nine-stage pipeline.
// Depends on bptc_pkg for widths, register indexes and constants.
//
// Usage:
//   csr_*  : calibration writes C1..C6 at csr_index 0..5, 16-bit csr_wdata.
//            csr_ready is always high; other indexes are dropped. Write only
//            while the pipeline is empty.
//   req_*  : one raw pressure / raw temperature pair per beat, taken when
//            req_valid is high and req_stall is low.
//   rsp_*  : one result beat per request: temperature in 0.01 C, pressure in
//            Pa and a flag set when pressure was clipped to 32 bits.
// A taken request beat passes the stages in order and shows as rsp_valid from
// the last one; throughput is one beat per cycle while rsp_stall is low.
// The clock rate is set by the slowest stage: a 25x25 multiply,
// the split 24x40 SENS product, or a 45-bit subtract plus clip.
// A stalled result holds in the output stage while empty stages upstream
// keep filling; req_stall rises only once all nine stages are full and
// rsp_stall is high.
// Reset clears all stage valids and sets every calibration word to zero.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation_unit (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire  [bptc_pkg::RAW_W-1:0]                  req_raw_pressure,
   input  wire  [bptc_pkg::RAW_W-1:0]                  req_raw_temperature,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic signed [bptc_pkg::TEMP_W-1:0]          rsp_temp_centideg,
   output logic signed [bptc_pkg::PRES_W-1:0]          rsp_pres_pascal,
   output logic                                        rsp_pressure_saturated,
   input  wire                                         csr_valid,
   output logic                                        csr_ready,
   input  wire  [bptc_pkg::CSR_IDX_W-1:0]              csr_index,
   input  wire  [bptc_pkg::COEF_W-1:0]                 csr_wdata
);

   localparam int RAW_W   = bptc_pkg::RAW_W;
   localparam int COEF_W  = bptc_pkg::COEF_W;
   localparam int DT_W    = bptc_pkg::DT_W;
   localparam int TEMP_W  = bptc_pkg::TEMP_W;
   localparam int MUL_W   = bptc_pkg::MUL_W;
   localparam int DSQ_W   = bptc_pkg::DSQ_W;
   localparam int OFF_W   = bptc_pkg::OFF_W;
   localparam int SENS_W  = bptc_pkg::SENS_W;
   localparam int SQ_W    = bptc_pkg::SQ_W;
   localparam int CORR_W  = bptc_pkg::CORR_W;
   localparam int SPLIT_W = bptc_pkg::SPLIT_W;
   localparam int PPLO_W  = bptc_pkg::PPLO_W;
   localparam int PPHI_W  = bptc_pkg::PPHI_W;
   localparam int PROD_W  = bptc_pkg::PROD_W;
   localparam int Q_W     = bptc_pkg::Q_W;
   localparam int NSTG    = bptc_pkg::NSTG;

   // ---------------- calibration registers ----------------
   logic [COEF_W-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bptc_pkg::REG_C1: c1_ff <= csr_wdata;
            bptc_pkg::REG_C2: c2_ff <= csr_wdata;
            bptc_pkg::REG_C3: c3_ff <= csr_wdata;
            bptc_pkg::REG_C4: c4_ff <= csr_wdata;
            bptc_pkg::REG_C5: c5_ff <= csr_wdata;
            bptc_pkg::REG_C6: c6_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   // A stage loads when it is empty or its successor loads this cycle.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] rdy;

   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[0];
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // ---------------- stage 1: dT ----------------
   logic [RAW_W-1:0]        s1_d1_ff;
   logic signed [DT_W-1:0]  s1_dt_ff, s1_dt_in;

   assign s1_dt_in = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, c5_ff, 8'd0});

   // ---------------- stage 2: dT products ----------------
   logic [RAW_W-1:0]         s2_d1_ff;
   logic signed [MUL_W-1:0]  s2_p6_ff, s2_p6_in;
   logic signed [MUL_W-1:0]  s2_p4_ff, s2_p4_in;
   logic signed [MUL_W-1:0]  s2_p3_ff, s2_p3_in;
   logic signed [DSQ_W-1:0]  s2_dsq_ff, s2_dsq_in;

   assign s2_p6_in  = s1_dt_ff * $signed({1'b0, c6_ff});
   assign s2_p4_in  = s1_dt_ff * $signed({1'b0, c4_ff});
   assign s2_p3_in  = s1_dt_ff * $signed({1'b0, c3_ff});
   assign s2_dsq_in = s1_dt_ff * s1_dt_ff;

   // ---------------- stage 3: first-order terms ----------------
   logic [RAW_W-1:0]          s3_d1_ff;
   logic signed [TEMP_W-1:0]  s3_temp_ff, s3_temp_in;
   logic signed [TEMP_W-1:0]  s3_a_ff, s3_a_in;     // TEMP - 2000
   logic signed [TEMP_W-1:0]  s3_b_ff, s3_b_in;     // TEMP + 1500
   logic signed [TEMP_W-1:0]  s3_t2_ff, s3_t2_in;
   logic                      s3_low_ff, s3_low_in;
   logic                      s3_vlow_ff, s3_vlow_in;
   logic signed [OFF_W-1:0]   s3_off_ff, s3_off_in;
   logic signed [SENS_W-1:0]  s3_sens_ff, s3_sens_in;

   assign s3_a_in    = s2_p6_ff[MUL_W-1:23];
   assign s3_temp_in = s3_a_in + bptc_pkg::TEMP_REF;
   assign s3_b_in    = s3_a_in + bptc_pkg::VLOW_OFS;
   assign s3_low_in  = s3_a_in[TEMP_W-1];
   assign s3_vlow_in = s3_b_in[TEMP_W-1];
   assign s3_t2_in   = s3_low_in ? $signed(s2_dsq_ff[DSQ_W-1:31]) : '0;
   assign s3_off_in  = $signed({10'd0, c2_ff, 16'd0})
                     + $signed({{7{s2_p4_ff[MUL_W-1]}}, s2_p4_ff[MUL_W-1:7]});
   assign s3_sens_in = $signed({9'd0, c1_ff, 15'd0})
                     + $signed({{6{s2_p3_ff[MUL_W-1]}}, s2_p3_ff[MUL_W-1:8]});

   // ---------------- stage 4: squares ----------------
   logic [RAW_W-1:0]          s4_d1_ff;
   logic signed [TEMP_W-1:0]  s4_temp_ff, s4_t2_ff;
   logic                      s4_low_ff, s4_vlow_ff;
   logic signed [OFF_W-1:0]   s4_off_ff;
   logic signed [SENS_W-1:0]  s4_sens_ff;
   logic [SQ_W-1:0]           s4_asq_ff, s4_asq_in;
   logic [SQ_W-1:0]           s4_bsq_ff, s4_bsq_in;
   logic signed [2*TEMP_W-1:0] asq_full, bsq_full;

   assign asq_full  = s3_a_ff * s3_a_ff;
   assign bsq_full  = s3_b_ff * s3_b_ff;
   assign s4_asq_in = asq_full[SQ_W-1:0];
   assign s4_bsq_in = bsq_full[SQ_W-1:0];

   // ---------------- stage 5: OFF2 / SENS2 ----------------
   logic [RAW_W-1:0]          s5_d1_ff;
   logic signed [TEMP_W-1:0]  s5_temp_ff, s5_t2_ff;
   logic signed [OFF_W-1:0]   s5_off_ff;
   logic signed [SENS_W-1:0]  s5_sens_ff;
   logic [CORR_W-1:0]         s5_off2_ff, s5_off2_in;
   logic [CORR_W-1:0]         s5_sens2_ff, s5_sens2_in;
   logic [CORR_W-1:0]         a5, b7, b11;

   assign a5  = {4'd0, s4_asq_ff} + {2'd0, s4_asq_ff, 2'd0};
   assign b7  = {1'd0, s4_bsq_ff, 3'd0} - {4'd0, s4_bsq_ff};
   assign b11 = {1'd0, s4_bsq_ff, 3'd0} + {3'd0, s4_bsq_ff, 1'd0} + {4'd0, s4_bsq_ff};

   always_comb begin
      s5_off2_in  = '0;
      s5_sens2_in = '0;
      if (s4_low_ff) begin
         s5_off2_in  = (a5 >> 1) + (s4_vlow_ff ? b7 : '0);
         s5_sens2_in = (a5 >> 2) + (s4_vlow_ff ? (b11 >> 1) : '0);
      end
   end

   // ---------------- stage 6: apply corrections ----------------
   logic [RAW_W-1:0]          s6_d1_ff;
   logic signed [TEMP_W-1:0]  s6_temp_ff, s6_temp_in;
   logic signed [OFF_W-1:0]   s6_off_ff, s6_off_in;
   logic signed [SENS_W-1:0]  s6_sens_ff, s6_sens_in;

   assign s6_temp_in = s5_temp_ff - s5_t2_ff;
   assign s6_off_in  = s5_off_ff - $signed({2'd0, s5_off2_ff});
   assign s6_sens_in = s5_sens_ff - $signed(s5_sens2_ff);

   // ---------------- stage 7: split D1*SENS partial products ----------------
   logic signed [TEMP_W-1:0]  s7_temp_ff;
   logic signed [OFF_W-1:0]   s7_off_ff;
   logic [PPLO_W-1:0]         s7_pplo_ff, s7_pplo_in;
   logic signed [PPHI_W-1:0]  s7_pphi_ff, s7_pphi_in;

   assign s7_pplo_in = s6_d1_ff * s6_sens_ff[SPLIT_W-1:0];
   assign s7_pphi_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens_ff[SENS_W-1:SPLIT_W]);

   // ---------------- stage 8: combine product ----------------
   logic signed [TEMP_W-1:0]  s8_temp_ff;
   logic signed [OFF_W-1:0]   s8_off_ff;
   logic signed [PROD_W-1:0]  s8_prod_ff, s8_prod_in;

   assign s8_prod_in = $signed({s7_pphi_ff[PPHI_W-2:0], 20'd0})
                     + $signed({20'd0, s7_pplo_ff});

   // ---------------- stage 9: pressure and clip ----------------
   logic signed [Q_W-1:0]     q;
   logic signed [63:0]        p_wide;
   logic signed [bptc_pkg::PRES_W-1:0] s9_pres_ff, s9_pres_in;
   logic                      s9_sat_ff, s9_sat_in;
   logic signed [TEMP_W-1:0]  s9_temp_ff;

   assign q      = $signed({{2{s8_prod_ff[PROD_W-1]}}, s8_prod_ff[PROD_W-1:21]})
                 - $signed({{3{s8_off_ff[OFF_W-1]}}, s8_off_ff});
   assign p_wide = $signed({{34{q[Q_W-1]}}, q[Q_W-1:15]});

   always_comb begin
      s9_sat_in  = 1'b0;
      s9_pres_in = p_wide[bptc_pkg::PRES_W-1:0];
      if (p_wide > bptc_pkg::PRES_MAX) begin
         s9_pres_in = bptc_pkg::PRES_MAX[bptc_pkg::PRES_W-1:0];
         s9_sat_in  = 1'b1;
      end else if (p_wide < bptc_pkg::PRES_MIN) begin
         s9_pres_in = bptc_pkg::PRES_MIN[bptc_pkg::PRES_W-1:0];
         s9_sat_in  = 1'b1;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_d1_ff <= req_raw_pressure;
         s1_dt_ff <= s1_dt_in;
      end
      if (rdy[1]) begin
         s2_d1_ff  <= s1_d1_ff;
         s2_p6_ff  <= s2_p6_in;
         s2_p4_ff  <= s2_p4_in;
         s2_p3_ff  <= s2_p3_in;
         s2_dsq_ff <= s2_dsq_in;
      end
      if (rdy[2]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s3_temp_in;
         s3_a_ff    <= s3_a_in;
         s3_b_ff    <= s3_b_in;
         s3_t2_ff   <= s3_t2_in;
         s3_low_ff  <= s3_low_in;
         s3_vlow_ff <= s3_vlow_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
      end
      if (rdy[3]) begin
         s4_d1_ff   <= s3_d1_ff;
         s4_temp_ff <= s3_temp_ff;
         s4_t2_ff   <= s3_t2_ff;
         s4_low_ff  <= s3_low_ff;
         s4_vlow_ff <= s3_vlow_ff;
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_asq_ff  <= s4_asq_in;
         s4_bsq_ff  <= s4_bsq_in;
      end
      if (rdy[4]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_temp_ff  <= s4_temp_ff;
         s5_t2_ff    <= s4_t2_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
      end
      if (rdy[5]) begin
         s6_d1_ff   <= s5_d1_ff;
         s6_temp_ff <= s6_temp_in;
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
      end
      if (rdy[6]) begin
         s7_temp_ff <= s6_temp_ff;
         s7_off_ff  <= s6_off_ff;
         s7_pplo_ff <= s7_pplo_in;
         s7_pphi_ff <= s7_pphi_in;
      end
      if (rdy[7]) begin
         s8_temp_ff <= s7_temp_ff;
         s8_off_ff  <= s7_off_ff;
         s8_prod_ff <= s8_prod_in;
      end
      if (rdy[8]) begin
         s9_temp_ff <= s8_temp_ff;
         s9_pres_ff <= s9_pres_in;
         s9_sat_ff  <= s9_sat_in;
      end
   end

   assign rsp_valid              = vld_ff[NSTG-1];
   assign rsp_temp_centideg      = s9_temp_ff;
   assign rsp_pres_pascal        = s9_pres_ff;
   assign rsp_pressure_saturated = s9_sat_ff;

   // ---------------- assertions ----------------
   // clip flag only ever accompanies a bound value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pressure_saturated) |->
         (rsp_pres_pascal == bptc_pkg::PRES_MAX[bptc_pkg::PRES_W-1:0] ||
          rsp_pres_pascal == bptc_pkg::PRES_MIN[bptc_pkg::PRES_W-1:0]))
      else $error("saturation flag without clipped pressure");

   // input back-pressure only when the whole pipe is full and blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&vld_ff) && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   // a blocked mid-pipe stage keeps its item and its payload
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && !rdy[4]) |=> (vld_ff[4] && $stable(s5_off2_ff) && $stable(s5_sens_ff)))
      else $error("blocked stage lost or changed its beat");

   // an accepted beat always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request beat dropped");

endmodule

`default_nettype wire

@@ test/tb_baro_pressure_temp_compensation_unit.sv @@
`timescale 1ns / 1ps
// Testbench for the barometric compensation pipeline. It drives raw pressure and
// temperature pairs under several calibration sets and checks every result beat.
// Depends on bptc_pkg and baro_pressure_temp_compensation_unit.

module tb_baro_pressure_temp_compensation_unit;

   localparam int RAW_W        = bptc_pkg::RAW_W;
   localparam int COEF_W       = bptc_pkg::COEF_W;
   localparam int CSR_IDX_W    = bptc_pkg::CSR_IDX_W;
   localparam int TEMP_W       = bptc_pkg::TEMP_W;
   localparam int PRES_W       = bptc_pkg::PRES_W;
   localparam int NSTG         = bptc_pkg::NSTG;
   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES  = 60;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 2 * NSTG;
   localparam int NUM_COEF     = 6;
   localparam logic [RAW_W-1:0]     RAW_MAX     = {RAW_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_centideg;
      logic signed [PRES_W-1:0] pres_pascal;
      logic                     pressure_saturated;
   } reading_type;

   class compensation_checker;
      logic [COEF_W-1:0] coef [NUM_COEF];
      reading_type       expected_readings [$];
      int                mismatches;

      function new();
         foreach (coef[i]) coef[i] = '0;
         mismatches = 0;
      endfunction

      function void set_coef(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
         if (idx <= bptc_pkg::REG_C6) coef[idx] = val;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function reading_type compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
         longint tref, tvlow, dt, temp, off, sens, p, t2, a, b, off2, sens2;
         reading_type r;
         tref  = bptc_pkg::TEMP_REF;
         tvlow = longint'(bptc_pkg::TEMP_REF) - longint'(bptc_pkg::VLOW_OFS);
         dt    = longint'(d2) - longint'(coef[bptc_pkg::REG_C5]) * 256;
         temp  = tref + ((dt * longint'(coef[bptc_pkg::REG_C6])) >>> 23);
         off   = longint'(coef[bptc_pkg::REG_C2]) * 65536
               + ((longint'(coef[bptc_pkg::REG_C4]) * dt) >>> 7);
         sens  = longint'(coef[bptc_pkg::REG_C1]) * 32768
               + ((longint'(coef[bptc_pkg::REG_C3]) * dt) >>> 8);
         // second-order terms; thresholds use the first-order temperature
         if (temp < tref) begin
            t2    = (dt * dt) >>> 31;
            a     = temp - tref;
            off2  = (5 * (a * a)) / 2;
            sens2 = (5 * (a * a)) / 4;
            if (temp < tvlow) begin
               b     = temp - tvlow;
               off2  += 7 * (b * b);
               sens2 += (11 * (b * b)) / 2;
            end
            temp -= t2;
            off  -= off2;
            sens -= sens2;
         end
         p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
         r.pressure_saturated = 1'b0;
         if (p > bptc_pkg::PRES_MAX) begin
            p = bptc_pkg::PRES_MAX;
            r.pressure_saturated = 1'b1;
         end else if (p < bptc_pkg::PRES_MIN) begin
            p = bptc_pkg::PRES_MIN;
            r.pressure_saturated = 1'b1;
         end
         r.temp_centideg = temp[TEMP_W-1:0];
         r.pres_pascal   = p[PRES_W-1:0];
         return r;
      endfunction

      function void note_pair(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
         expected_readings.push_back(compensate(d1, d2));
      endfunction

      function void check_result(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            $error("result beat with nothing pending: temp_centideg %0d, pres_pascal %0d",
                   got.temp_centideg, got.pres_pascal);
            mismatches++;
            return;
         end
         want = expected_readings.pop_front();
         if (got.temp_centideg !== want.temp_centideg) begin
            $error("temp_centideg: expected %0d, got %0d",
                   want.temp_centideg, got.temp_centideg);
            mismatches++;
         end
         if (got.pres_pascal !== want.pres_pascal) begin
            $error("pres_pascal: expected %0d, got %0d", want.pres_pascal, got.pres_pascal);
            mismatches++;
         end
         if (got.pressure_saturated !== want.pressure_saturated) begin
            $error("pressure_saturated: expected %0b, got %0b",
                   want.pressure_saturated, got.pressure_saturated);
            mismatches++;
         end
      endfunction
   endclass

   logic                        clock               = 1'b0;
   logic                        reset               = 1'b1;
   logic                        req_valid           = 1'b0;
   logic [RAW_W-1:0]            req_raw_pressure    = '0;
   logic [RAW_W-1:0]            req_raw_temperature = '0;
   logic                        rsp_stall           = 1'b0;
   logic                        csr_valid           = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index           = '0;
   logic [COEF_W-1:0]           csr_wdata           = '0;
   logic                        req_stall;
   logic                        rsp_valid;
   logic signed [TEMP_W-1:0]    rsp_temp_centideg;
   logic signed [PRES_W-1:0]    rsp_pres_pascal;
   logic                        rsp_pressure_saturated;
   logic                        csr_ready;

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   bit  hold_rsp      = 1'b0;
   int  idle_cycles   = 0;

   compensation_checker comp_check = new();

   baro_pressure_temp_compensation_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_raw_pressure       (req_raw_pressure),
      .req_raw_temperature    (req_raw_temperature),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_temp_centideg      (rsp_temp_centideg),
      .rsp_pres_pascal        (rsp_pres_pascal),
      .rsp_pressure_saturated (rsp_pressure_saturated),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // result side: random stall, or a long hold-off when asked for
   always begin
      @(negedge clock);
      if (hold_rsp) begin
         hold_rsp = 1'b0;
         for (int i = 0; i < HOLD_CYCLES; i++) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      reading_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.temp_centideg      = rsp_temp_centideg;
            got.pres_pascal        = rsp_pres_pascal;
            got.pressure_saturated = rsp_pressure_saturated;
            comp_check.check_result(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb_baro_pressure_temp_compensation_unit NOT OK");
      $finish;
   end

   function automatic void set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 76; stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 76; end
         IDLE_BOTH: begin send_idle_pct = 6;  stall_pct = 6;  end
         default:   begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] clamp_raw(longint v);
      if (v < 0) return '0;
      if (v > longint'(RAW_MAX)) return RAW_MAX;
      return v[RAW_W-1:0];
   endfunction

   // lowest raw temperature that still reads -15.00 C or above
   function automatic longint vlow_raw_temp();
      if (comp_check.coef[bptc_pkg::REG_C6] == 0) return 0;
      return longint'(comp_check.coef[bptc_pkg::REG_C5]) * 256
             - (longint'(bptc_pkg::VLOW_OFS) * (longint'(1) << 23))
               / longint'(comp_check.coef[bptc_pkg::REG_C6]);
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw_temp();
      longint ref_raw, v;
      ref_raw = longint'(comp_check.coef[bptc_pkg::REG_C5]) * 256;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(RAW_MAX);
         4, 5, 6:    v = ref_raw + longint'($urandom_range(131072)) - 65536;
         7:          v = ref_raw - longint'($urandom_range(1));
         8:          v = vlow_raw_temp() - longint'($urandom_range(1));
         default:    v = $urandom_range(1) ? longint'(RAW_MAX) : 0;
      endcase
      return clamp_raw(v);
   endfunction

   task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_raw_pressure    <= d1;
      req_raw_temperature <= d2;
      do @(posedge clock); while (req_stall);
      comp_check.note_pair(d1, d2);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      logic [RAW_W-1:0] d1;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0)
            d1 = $urandom_range(1) ? RAW_MAX : {RAW_W{1'b0}};
         else
            d1 = RAW_W'($urandom_range(RAW_MAX));
         send_pair(d1, pick_raw_temp());
      end
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(negedge clock);
      while (comp_check.pending() != 0) @(negedge clock);
      repeat (NSTG + 2) @(negedge clock);
   endtask

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      comp_check.set_coef(idx, val);
      @(negedge clock);
   endtask

   // spare indexes get a beat too; the block must drop them
   task automatic load_calibration(input logic [COEF_W-1:0] cal [NUM_COEF]);
      for (int i = 0; i < NUM_COEF; i++) write_coef(CSR_IDX_W'(i), cal[i]);
      write_coef(REG_SPARE_A, COEF_W'($urandom()));
      write_coef(REG_SPARE_B, COEF_W'($urandom()));
      csr_valid <= 1'b0;
   endtask

   initial begin
      longint            temp_edges [6];
      logic [COEF_W-1:0] cal [NUM_COEF];

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all calibration words still zero from reset
      set_idle(IDLE_NONE);
      send_pair('0, '0);
      send_pair(RAW_MAX, RAW_MAX);
      send_pair(RAW_MAX, '0);
      drain_pipeline();

      // typical factory calibration; cover both correction thresholds
      cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
      load_calibration(cal);
      temp_edges = '{0, longint'(RAW_MAX),
                     longint'(cal[bptc_pkg::REG_C5]) * 256,
                     longint'(cal[bptc_pkg::REG_C5]) * 256 - 1,
                     vlow_raw_temp(), vlow_raw_temp() - 1};
      foreach (temp_edges[k]) begin
         send_pair('0, clamp_raw(temp_edges[k]));
         send_pair(RAW_MAX, clamp_raw(temp_edges[k]));
      end
      hold_rsp = 1'b1;
      send_random(150);
      drain_pipeline();

      cal = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      load_calibration(cal);
      set_idle(IDLE_SEND);
      send_random(100);
      drain_pipeline();

      cal = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
      load_calibration(cal);
      set_idle(IDLE_RECV);
      send_random(100);
      drain_pipeline();

      foreach (cal[i]) cal[i] = COEF_W'($urandom());
      load_calibration(cal);
      set_idle(IDLE_BOTH);
      hold_rsp = 1'b1;
      send_random(100);
      drain_pipeline();

      foreach (cal[i]) cal[i] = COEF_W'($urandom());
      load_calibration(cal);
      set_idle(IDLE_RECV);
      send_random(100);
      drain_pipeline();

      cal = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001};
      load_calibration(cal);
      set_idle(IDLE_SEND);
      send_random(100);
      drain_pipeline();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (comp_check.mismatches == 0 && comp_check.pending() == 0)
         $display("tb_baro_pressure_temp_compensation_unit OK");
      else
         $display("tb_baro_pressure_temp_compensation_unit NOT OK");
      $finish;
   end

endmodule
